### design/scbp_pkg.sv
// ----------------------------------------------------------------------------
// scbp_pkg
// Shared types and codes of the size-class receive buffer pool.
// ----------------------------------------------------------------------------
package scbp_pkg;

	localparam int CLASS_COUNT = 3;
	localparam int LEN_W       = 14;
	localparam int CAP_W       = 16;
	localparam int ID_W        = 6;
	localparam int CLS_W       = 2;
	localparam int STATUS_W    = 3;
	localparam int QCOUNT_W    = 6;
	localparam int CFG_IDX_W   = 2;

	// operation codes
	localparam logic OP_ARRIVE = 1'b0;
	localparam logic OP_READ   = 1'b1;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_STORED    = 3'd0;
	localparam logic [STATUS_W-1:0] ST_BAD_LEN   = 3'd1;
	localparam logic [STATUS_W-1:0] ST_NO_BUFFER = 3'd2;
	localparam logic [STATUS_W-1:0] ST_DELIVERED = 3'd3;
	localparam logic [STATUS_W-1:0] ST_DISCARDED = 3'd4;
	localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd5;

	// buffer classes
	localparam logic [CLS_W-1:0] CLS_SMALL  = 2'd0;
	localparam logic [CLS_W-1:0] CLS_MEDIUM = 2'd1;
	localparam logic [CLS_W-1:0] CLS_LARGE  = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SMALL_LIMIT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MEDIUM_LIMIT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LARGE_LIMIT  = 2'd2;

	// configuration reset values
	localparam logic [LEN_W-1:0] SMALL_LIMIT_RST  = 14'd256;
	localparam logic [LEN_W-1:0] MEDIUM_LIMIT_RST = 14'd4352;
	localparam logic [LEN_W-1:0] LARGE_LIMIT_RST  = 14'd8192;

	typedef struct packed {
		logic             operation;
		logic [LEN_W-1:0] packet_length;
		logic [CAP_W-1:0] reader_capacity;
	} scbp_req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [ID_W-1:0]     buffer_id;
		logic [CLS_W-1:0]    buffer_class;
		logic [LEN_W-1:0]    delivered_length;
		logic [QCOUNT_W-1:0] queued_packets;
	} scbp_rsp_t;

	// one ready-queue entry
	typedef struct packed {
		logic [ID_W-1:0]  id;
		logic [CLS_W-1:0] cls;
		logic [LEN_W-1:0] len;
	} scbp_entry_t;

	// free-list commands: pop at acceptance, push on release
	typedef struct packed {
		logic             pop;
		logic [CLS_W-1:0] pop_cls;
		logic             push;
		logic [CLS_W-1:0] push_cls;
		logic [ID_W-1:0]  push_id;
	} scbp_fl_cmd_t;

	// ready-queue commands
	typedef struct packed {
		logic        pop;
		logic        push;
		scbp_entry_t push_entry;
	} scbp_rq_cmd_t;

endpackage

### design/scbp_free_list.sv
// ----------------------------------------------------------------------------
// scbp_free_list
// Three circular free lists of buffer ids sharing one memory, one region per
// class. Entries never written read as their power-up id.
// ----------------------------------------------------------------------------
module scbp_free_list import scbp_pkg::*; #(
	parameter int SMALL_BUFFERS  = 5,
	parameter int MEDIUM_BUFFERS = 40,
	parameter int LARGE_BUFFERS  = 2
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  scbp_fl_cmd_t           cmd,
	output logic [CLASS_COUNT-1:0] avail,
	output logic [ID_W-1:0]        pop_id
);

	localparam int TOTAL = SMALL_BUFFERS + MEDIUM_BUFFERS + LARGE_BUFFERS;
	localparam int AW    = $clog2(TOTAL);
	localparam int XW    = $clog2(2 * TOTAL);
	localparam int MAXSM = (SMALL_BUFFERS > MEDIUM_BUFFERS) ? SMALL_BUFFERS : MEDIUM_BUFFERS;
	localparam int MAXD  = (MAXSM > LARGE_BUFFERS) ? MAXSM : LARGE_BUFFERS;
	localparam int HW    = (MAXD > 1) ? $clog2(MAXD) : 1;
	localparam int CW    = $clog2(MAXD + 1);
	localparam int DEPTH [CLASS_COUNT] = '{SMALL_BUFFERS, MEDIUM_BUFFERS, LARGE_BUFFERS};
	localparam int BASE  [CLASS_COUNT] = '{0, SMALL_BUFFERS, SMALL_BUFFERS + MEDIUM_BUFFERS};

	logic [ID_W-1:0] mem [TOTAL];
	logic [TOTAL-1:0] written_q;
	logic [HW-1:0]    head_q  [CLASS_COUNT];
	logic [CW-1:0]    count_q [CLASS_COUNT];

	logic [ID_W-1:0]  rd_mem_q;
	logic             rd_written_q;
	logic [ID_W-1:0]  rd_dflt_q;

	logic [AW-1:0]          pop_addr;
	logic [AW-1:0]          push_addr;
	logic [XW-1:0]          push_pos;
	logic [XW-1:0]          push_wrap;
	logic                   push_ok;
	logic [CLASS_COUNT-1:0] do_pop;
	logic [CLASS_COUNT-1:0] do_push;

	always_comb begin
		pop_addr  = AW'(XW'(BASE[cmd.pop_cls]) + XW'(head_q[cmd.pop_cls]));
		push_pos  = XW'(head_q[cmd.push_cls]) + XW'(count_q[cmd.push_cls]);
		push_wrap = (push_pos >= XW'(DEPTH[cmd.push_cls])) ?
			push_pos - XW'(DEPTH[cmd.push_cls]) : push_pos;
		push_addr = AW'(XW'(BASE[cmd.push_cls]) + push_wrap);
		// a full list ignores the return
		push_ok   = XW'(count_q[cmd.push_cls]) < XW'(DEPTH[cmd.push_cls]);
		for (int i = 0; i < CLASS_COUNT; i++) begin
			do_pop[i]  = cmd.pop && (cmd.pop_cls == CLS_W'(i));
			do_push[i] = cmd.push && push_ok && (cmd.push_cls == CLS_W'(i));
		end
	end

	for (genvar g = 0; g < CLASS_COUNT; g++) begin : g_avail
		assign avail[g] = (count_q[g] != '0);
	end

	// untouched entries hold their own position as id
	assign pop_id = rd_written_q ? rd_mem_q : rd_dflt_q;

	always_ff @(posedge clk) begin
		if (cmd.push && push_ok) begin
			mem[push_addr] <= cmd.push_id;
		end
		if (cmd.pop) begin
			rd_mem_q  <= mem[pop_addr];
			rd_dflt_q <= ID_W'(pop_addr);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q    <= '0;
			rd_written_q <= 1'b0;
			for (int i = 0; i < CLASS_COUNT; i++) begin
				head_q[i]  <= '0;
				count_q[i] <= CW'(DEPTH[i]);
			end
		end else begin
			if (cmd.push && push_ok) begin
				written_q[push_addr] <= 1'b1;
			end
			if (cmd.pop) begin
				rd_written_q <= written_q[pop_addr];
			end
			for (int i = 0; i < CLASS_COUNT; i++) begin
				if (do_pop[i]) begin
					head_q[i] <= (XW'(head_q[i]) == XW'(DEPTH[i] - 1)) ? '0 : head_q[i] + 1'b1;
				end
				if (do_pop[i] && !do_push[i]) begin
					count_q[i] <= count_q[i] - 1'b1;
				end else if (do_push[i] && !do_pop[i]) begin
					count_q[i] <= count_q[i] + 1'b1;
				end
			end
		end
	end

endmodule

### design/scbp_ready_queue.sv
// ----------------------------------------------------------------------------
// scbp_ready_queue
// Circular queue of stored packets in one memory, registered read port.
// ----------------------------------------------------------------------------
module scbp_ready_queue import scbp_pkg::*; #(
	parameter int TOTAL = 47
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  scbp_rq_cmd_t                cmd,
	output logic [$clog2(TOTAL+1)-1:0]  count,
	output scbp_entry_t                 pop_entry
);

	localparam int AW = $clog2(TOTAL);
	localparam int CW = $clog2(TOTAL + 1);
	localparam int XW = $clog2(2 * TOTAL);

	scbp_entry_t   mem [TOTAL];
	logic [AW-1:0] head_q;
	logic [CW-1:0] count_q;
	scbp_entry_t   rd_q;

	logic [XW-1:0] tail_pos;
	logic [AW-1:0] tail_addr;

	always_comb begin
		tail_pos  = XW'(head_q) + XW'(count_q);
		tail_addr = AW'((tail_pos >= XW'(TOTAL)) ? tail_pos - XW'(TOTAL) : tail_pos);
	end

	assign count     = count_q;
	assign pop_entry = rd_q;

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			mem[tail_addr] <= cmd.push_entry;
		end
		if (cmd.pop) begin
			rd_q <= mem[head_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else begin
			if (cmd.pop) begin
				head_q <= (XW'(head_q) == XW'(TOTAL - 1)) ? '0 : head_q + 1'b1;
			end
			if (cmd.pop && !cmd.push) begin
				count_q <= count_q - 1'b1;
			end else if (cmd.push && !cmd.pop) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

endmodule

### design/size_class_buffer_pool_core.sv
// A taken request word waits in stage 1, then commits into the output register.
// A new request word is taken only once stage 1 is empty; the memory read issued
// at acceptance and the read-modify-write commit after it form the per-word loop.
// Reset (arst_n low): limits return to 256/4352/8192, every free list is full
// in id order (per-entry written bits, no clearing pass), the queue is empty.
// ----------------------------------------------------------------------------
// size_class_buffer_pool_core
// Receive buffer pool with small, medium and large classes and an in-order
// ready queue of stored packets.
// ----------------------------------------------------------------------------
module size_class_buffer_pool_core import scbp_pkg::*; #(
	parameter int SMALL_BUFFERS  = 5,
	parameter int MEDIUM_BUFFERS = 40,
	parameter int LARGE_BUFFERS  = 2,
	parameter int LARGEST_PACKET = 8192
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// request channel
	input  logic                 req_valid,
	output logic                 req_ready,
	input  scbp_req_t            req,
	// result channel
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	output scbp_rsp_t            rsp,
	// configuration write channel
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [LEN_W-1:0]     cfg_data
);

	localparam int TOTAL = SMALL_BUFFERS + MEDIUM_BUFFERS + LARGE_BUFFERS;
	localparam int QCW   = $clog2(TOTAL + 1);

	// ---------------------------------------------------------------- config
	logic [LEN_W-1:0] small_limit_q;
	logic [LEN_W-1:0] medium_limit_q;
	logic [LEN_W-1:0] large_limit_q;

	// registers are always writable; writes must come only while idle, which the block does not enforce
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			small_limit_q  <= SMALL_LIMIT_RST;
			medium_limit_q <= MEDIUM_LIMIT_RST;
			large_limit_q  <= LARGE_LIMIT_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_SMALL_LIMIT:  small_limit_q  <= cfg_data;
				REG_MEDIUM_LIMIT: medium_limit_q <= cfg_data;
				REG_LARGE_LIMIT:  large_limit_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------- storage
	scbp_fl_cmd_t           fl_cmd;
	logic [CLASS_COUNT-1:0] fl_avail;
	logic [ID_W-1:0]        fl_id;
	scbp_rq_cmd_t           rq_cmd;
	logic [QCW-1:0]         rq_count;
	scbp_entry_t            rq_entry;

	scbp_free_list #(
		.SMALL_BUFFERS  (SMALL_BUFFERS),
		.MEDIUM_BUFFERS (MEDIUM_BUFFERS),
		.LARGE_BUFFERS  (LARGE_BUFFERS)
	) u_free_list (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (fl_cmd),
		.avail  (fl_avail),
		.pop_id (fl_id)
	);

	scbp_ready_queue #(
		.TOTAL (TOTAL)
	) u_ready_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (rq_cmd),
		.count     (rq_count),
		.pop_entry (rq_entry)
	);

	// ---------------------------------------------------------------- stage 0
	// Decide at acceptance: length check, class pick, and issue the memory
	// read (free-list pop for an arrival, queue pop for a read).
	logic                req_take;
	logic                is_arrive;
	logic                len_bad;
	logic                fit_small;
	logic                fit_medium;
	logic                fit_large;
	logic                rq_full;
	logic [CLS_W-1:0]    pick_cls;
	logic [STATUS_W-1:0] status_d;
	logic [QCW-1:0]      qcount_d;

	logic                valid_s1;
	logic                op_s1;
	logic [STATUS_W-1:0] status_s1;
	logic [CLS_W-1:0]    cls_s1;
	logic [LEN_W-1:0]    len_s1;
	logic [CAP_W-1:0]    cap_s1;
	logic [QCW-1:0]      qcount_s1;

	logic                out_valid_q;
	scbp_rsp_t           out_q;

	assign req_ready = !valid_s1;
	assign req_take  = req_valid && req_ready;
	assign is_arrive = (req.operation == OP_ARRIVE);

	always_comb begin
		len_bad    = (req.packet_length == '0) || (req.packet_length > large_limit_q) ||
			(req.packet_length > LEN_W'(LARGEST_PACKET));
		fit_small  = (req.packet_length <= small_limit_q) && fl_avail[CLS_SMALL];
		fit_medium = (req.packet_length <= medium_limit_q) && fl_avail[CLS_MEDIUM];
		fit_large  = (req.packet_length <= large_limit_q) && fl_avail[CLS_LARGE];
		rq_full    = (rq_count >= QCW'(TOTAL));

		// smallest class that fits and has a free buffer
		if (fit_small) begin
			pick_cls = CLS_SMALL;
		end else if (fit_medium) begin
			pick_cls = CLS_MEDIUM;
		end else begin
			pick_cls = CLS_LARGE;
		end

		qcount_d = rq_count;
		if (is_arrive) begin
			if (len_bad) begin
				status_d = ST_BAD_LEN;
			end else if (!(fit_small || fit_medium || fit_large) || rq_full) begin
				status_d = ST_NO_BUFFER;
			end else begin
				status_d = ST_STORED;
				qcount_d = rq_count + 1'b1;
			end
		end else if (rq_count == '0) begin
			status_d = ST_EMPTY;
		end else begin
			// final delivered / discarded call waits for the entry
			status_d = ST_DELIVERED;
			qcount_d = rq_count - 1'b1;
		end
	end

	// ---------------------------------------------------------------- stage 1
	// Read data is back: build the result word, push the entry or return the
	// buffer. Hold while the output register is full and not drained.
	logic                commit;
	logic                stored_s1;
	logic                popped_s1;
	logic [STATUS_W-1:0] rsp_status;
	scbp_rsp_t           rsp_d;

	assign commit    = valid_s1 && (!out_valid_q || rsp_ready);
	assign stored_s1 = (op_s1 == OP_ARRIVE) && (status_s1 == ST_STORED);
	assign popped_s1 = (op_s1 == OP_READ) && (status_s1 == ST_DELIVERED);

	always_comb begin
		rsp_status = status_s1;
		if (popped_s1 && (CAP_W'(rq_entry.len) > cap_s1)) begin
			rsp_status = ST_DISCARDED;
		end

		rsp_d.status         = rsp_status;
		rsp_d.queued_packets = QCOUNT_W'(qcount_s1);
		if (stored_s1) begin
			rsp_d.buffer_id        = fl_id;
			rsp_d.buffer_class     = cls_s1;
			rsp_d.delivered_length = len_s1;
		end else if (popped_s1) begin
			rsp_d.buffer_id        = rq_entry.id;
			rsp_d.buffer_class     = rq_entry.cls;
			rsp_d.delivered_length = rq_entry.len;
		end else begin
			rsp_d.buffer_id        = '0;
			rsp_d.buffer_class     = '0;
			rsp_d.delivered_length = '0;
		end

		// pop the free list at acceptance, return the buffer on commit
		fl_cmd.pop      = req_take && is_arrive && (status_d == ST_STORED);
		fl_cmd.pop_cls  = pick_cls;
		fl_cmd.push     = commit && popped_s1 && (rq_entry.cls <= CLS_LARGE);
		fl_cmd.push_cls = rq_entry.cls;
		fl_cmd.push_id  = rq_entry.id;

		// pop the queue at acceptance, append the new packet on commit
		rq_cmd.pop            = req_take && !is_arrive && (status_d == ST_DELIVERED);
		rq_cmd.push           = commit && stored_s1;
		rq_cmd.push_entry.id  = fl_id;
		rq_cmd.push_entry.cls = cls_s1;
		rq_cmd.push_entry.len = len_s1;
	end

	always_ff @(posedge clk) begin
		if (req_take) begin
			op_s1     <= req.operation;
			status_s1 <= status_d;
			cls_s1    <= pick_cls;
			len_s1    <= req.packet_length;
			cap_s1    <= req.reader_capacity;
			qcount_s1 <= qcount_d;
		end
		if (commit) begin
			out_q <= rsp_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// advance stage 1 into the output register, drop it once taken
			if (req_take) begin
				valid_s1 <= 1'b1;
			end else if (commit) begin
				valid_s1 <= 1'b0;
			end
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

endmodule
